@@ design/assert_macros.svh @@
// Assertion macros shared by the deque core.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ design/cdeq_pkg.sv @@
// Package for the circular deque core: opcodes, status codes, FSM state,
// controller/datapath command and status bundles. No dependencies.
package cdeq_pkg;

    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_BACK   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POPW
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the input beat
        logic rd_issue;  // read the slot at the popped end
        logic finish;    // commit pointers/slot and register the result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op_pop;    // latched opcode is a pop
        logic q_empty;   // queue currently empty
    } stat_t;

endpackage

@@ design/circular_double_ended_queue_core.sv @@
// Top level of the circular deque core: controller plus datapath.
// Depends on cdeq_pkg, cdeq_ctrl, cdeq_dp and assert_macros.svh.

// Double-ended queue of DEPTH signed 32-bit words in a circular buffer.
// A beat is taken at a rising edge where start is high and busy is low;
// opcode selects push front, push back, pop front or pop back. Every beat
// gives exactly one result, shown for a single cycle with done high; the
// receiver cannot stall it, so capture it on that cycle. A push or a
// rejected operation (push into a full queue, pop from an empty one) passes
// through state S_EXEC before the done cycle; a successful pop passes through
// S_EXEC and S_POPW, the added state being the registered read of the slot
// memory. busy is low again during the done cycle, so the next beat may be
// accepted then; no new beat is taken while one is in flight. A rejected
// push reports status full, a rejected pop reports status empty with
// popped_value zero; neither changes the queue. now_full and now_empty give
// the queue's occupancy after the step. The first word pushed into an empty
// queue lands in slot zero whichever end is pushed, and popping the last
// word returns both pointers to slot zero. Slots need no clearing after
// reset: only written slots are ever popped.
module circular_double_ended_queue_core #(
    parameter int DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] push_value,
    output logic               done,
    output logic signed [31:0] popped_value,
    output logic [1:0]         status,
    output logic               now_full,
    output logic               now_empty
);
    import cdeq_pkg::*;

    `include "assert_macros.svh"

    cmd_t  cmd;    // sequencing from the controller
    stat_t stat;   // latched opcode class and occupancy back to it

    cdeq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    cdeq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .opcode       (opcode),
        .push_value   (push_value),
        .stat         (stat),
        .popped_value (popped_value),
        .status       (status),
        .now_full     (now_full),
        .now_empty    (now_empty),
        .done         (done)
    );

    // an accepted beat always occupies the block for the next cycle
    `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // result cycle leaves the block free for the next beat
    `ASSERT_SAME(a_done_idle, done, !busy)
    // a queue can never be both full and empty
    `ASSERT_SAME(a_full_empty, done, !(now_full && now_empty))
    // rejected pop: zero data and the queue is reported empty
    `ASSERT_SAME(a_empty_pop, done && (status == ST_EMPTY), (popped_value == 32'sd0) && now_empty)

endmodule

@@ design/cdeq_ctrl.sv @@
// Controller FSM of the circular deque core.
// Depends on cdeq_pkg.
module cdeq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  cdeq_pkg::stat_t stat,
    output cdeq_pkg::cmd_t  cmd,
    output logic            busy
);
    import cdeq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.op_pop && !stat.q_empty)
                begin
                    state_next = S_POPW;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_POPW:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_EXEC:
            begin
                // a pop that will succeed needs the registered slot read first
                if (stat.op_pop && !stat.q_empty)
                begin
                    cmd.rd_issue = 1'b1;
                end
                else
                begin
                    cmd.finish = 1'b1;
                end
            end
            S_POPW:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

@@ design/cdeq_dp.sv @@
// Datapath of the circular deque core: slot memory, head/tail pointers,
// empty flag and result registers. Depends on cdeq_pkg.
module cdeq_dp #(
    parameter int DEPTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cdeq_pkg::cmd_t      cmd,
    input  logic [1:0]          opcode,
    input  logic signed [31:0]  push_value,
    output cdeq_pkg::stat_t     stat,
    output logic signed [31:0]  popped_value,
    output logic [1:0]          status,
    output logic                now_full,
    output logic                now_empty,
    output logic                done
);
    import cdeq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic signed [31:0] mem [DEPTH];

    logic [1:0]         op_reg;
    logic signed [31:0] val_reg;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic               empty_reg, empty_next;
    logic signed [31:0] rd_data_reg;
    logic signed [31:0] popped_reg, popped_next;
    logic [1:0]         status_reg, status_next;
    logic               full_reg, full_next;
    logic               done_reg;

    logic               is_pop;
    logic               full_now;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
        return (i == LAST) ? '0 : i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
        return (i == '0) ? LAST : i - AW'(1);
    endfunction

    assign is_pop   = (op_reg == OP_POP_FRONT) || (op_reg == OP_POP_BACK);
    assign full_now = !empty_reg && (idx_inc(tail_reg) == head_reg);
    assign rd_addr  = (op_reg == OP_POP_FRONT) ? head_reg : tail_reg;

    assign stat.op_pop  = is_pop;
    assign stat.q_empty = empty_reg;

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        popped_next = '0;
        status_next = ST_DONE;
        if (cmd.finish)
        begin
            if (!is_pop)
            begin
                if (full_now)
                begin
                    status_next = ST_FULL;
                end
                else if (empty_reg)
                begin
                    // first word lands in slot zero from either end
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b0;
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                end
                else if (op_reg == OP_PUSH_FRONT)
                begin
                    head_next = idx_dec(head_reg);
                    wr_en     = 1'b1;
                    wr_addr   = idx_dec(head_reg);
                end
                else
                begin
                    tail_next = idx_inc(tail_reg);
                    wr_en     = 1'b1;
                    wr_addr   = idx_inc(tail_reg);
                end
            end
            else if (empty_reg)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                popped_next = rd_data_reg;
                if (head_reg == tail_reg)
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b1;
                end
                else if (op_reg == OP_POP_FRONT)
                begin
                    head_next = idx_inc(head_reg);
                end
                else
                begin
                    tail_next = idx_dec(tail_reg);
                end
            end
        end
    end

    assign full_next = !empty_next && (idx_inc(tail_next) == head_next);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
            done_reg  <= cmd.finish;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            val_reg <= push_value;
        end
        if (cmd.finish)
        begin
            popped_reg <= popped_next;
            status_reg <= status_next;
            full_reg   <= full_next;
        end
    end

    // slot memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= val_reg;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign now_full     = full_reg;
    assign now_empty    = empty_reg;
    assign done         = done_reg;

endmodule
